[hw/rtl/rgbh_pkg.sv]
// Shared types and constants for the RGB channel histogram.
package rgbh_pkg;

   localparam int MAX_LEVELS   = 16;
   localparam int COUNT_WIDTH  = 20;
   localparam int TOTAL_WIDTH  = COUNT_WIDTH + 2;
   localparam int NUM_CHANNELS = 3;
   localparam int STORE_DEPTH  = NUM_CHANNELS * MAX_LEVELS;
   localparam int BIN_WIDTH    = $clog2(MAX_LEVELS);
   localparam int LVL_WIDTH    = $clog2(MAX_LEVELS + 1);
   localparam int NUM_WIDTH    = COUNT_WIDTH + 16;
   localparam int DIV_STEPS    = NUM_WIDTH;
   localparam int STEP_WIDTH   = $clog2(DIV_STEPS + 1);

   localparam logic [0:0] REQ_PIXEL = 1'b0;
   localparam logic [0:0] REQ_FRAME = 1'b1;

   localparam logic [0:0] REG_NUM_LEVELS    = 1'b0;
   localparam logic [0:0] REG_MAX_INTENSITY = 1'b1;

   typedef struct packed {
      logic [0:0] req_type;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type_type;

   typedef struct packed {
      logic [5:0]  bin_index;
      logic [19:0] bin_count;
      logic [15:0] bin_fraction;
      logic        last_bin;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic accum;
      logic load_bin;
      logic div_start;
      logic div_step;
      logic emit;
      logic clear_step;
      logic clear_done;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic div_done;
      logic walk_last;
      logic clear_last;
   } stat_type;

endpackage

[hw/rtl/rgb_channel_histogram_top.sv]
// A pixel request is absorbed at its accepting edge and busy stays low; while busy is low, one
// pixel a cycle is taken. An end-of-frame request walks 3*L bins, each with a load, a 36-step
// divide and an emit; a clear sweep over every bin slot follows, and busy stays high until it
// ends. The receiver cannot stall; each result is on rsp_ for one cycle with rsp_valid high.
// Reset (synchronous) runs the same clear sweep with busy high; registers return to 16 levels
// and intensity 255.
module rgb_channel_histogram_top
   import rgbh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:2]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic [4:0] num_levels_ff;
   logic [7:0] max_int_ff;
   cmd_type    cmd;
   stat_type   stat;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff <= 5'd16;
         max_int_ff    <= 8'd255;
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[2])
            REG_NUM_LEVELS:    num_levels_ff <= pwdata[4:0];
            REG_MAX_INTENSITY: max_int_ff    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_NUM_LEVELS:    prdata = {27'd0, num_levels_ff};
         REG_MAX_INTENSITY: prdata = {24'd0, max_int_ff};
         default:           prdata = '0;
      endcase
   end

   rgbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_frame (req_data.req_type == REQ_FRAME),
      .stat      (stat),
      .busy      (busy),
      .cmd       (cmd)
   );

   rgbh_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_data),
      .num_levels (num_levels_ff),
      .peak_level (max_int_ff),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_data)
   );

endmodule

[hw/rtl/rgbh_ctrl.sv]
// Controller state machine: accumulate, emit walk with division, clear sweep.
module rgbh_ctrl
   import rgbh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     req_frame,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_EMIT  = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_frame) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.accum = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_bin = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (stat.walk_last) begin
               state_in = ST_CLEAR;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               cmd.clear_done = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      cmd.div_start = cmd.load_bin;
   end

endmodule

[hw/rtl/rgbh_dp.sv]
// Datapath: per-channel bin counters, binning, total, restoring divider and result register.
module rgbh_dp
   import rgbh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  req_type_type req,
   input  logic [4:0]   num_levels,
   input  logic [7:0]   peak_level,
   output stat_type     stat,
   output logic         rsp_valid,
   output rsp_type      rsp
);

   logic [COUNT_WIDTH-1:0] red_ff   [MAX_LEVELS];
   logic [COUNT_WIDTH-1:0] green_ff [MAX_LEVELS];
   logic [COUNT_WIDTH-1:0] blue_ff  [MAX_LEVELS];
   logic [TOTAL_WIDTH-1:0] total_ff;
   logic [BIN_WIDTH-1:0]   clr_ff;
   logic [1:0]             ch_ff;
   logic [BIN_WIDTH-1:0]   bin_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [NUM_WIDTH-1:0]   quo_ff;
   logic [TOTAL_WIDTH:0]   rem_ff;
   logic [STEP_WIDTH-1:0]  step_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [LVL_WIDTH-1:0] levels;
   logic [7:0]           m_eff;
   logic [5:0]           flat;
   logic                 top_bin;

   always_comb begin
      if (num_levels < 5'd2) begin
         levels = LVL_WIDTH'(2);
      end else if (num_levels > 5'(MAX_LEVELS)) begin
         levels = LVL_WIDTH'(MAX_LEVELS);
      end else begin
         levels = LVL_WIDTH'(num_levels);
      end
      m_eff = (peak_level == 8'd0) ? 8'd1 : peak_level;
   end

   // Bin is the highest b below lv with b*m <= v*(lv-1); this also saturates at lv-1.
   function automatic logic [BIN_WIDTH-1:0] bin_of(
      input logic [7:0] v, input logic [LVL_WIDTH-1:0] lv, input logic [7:0] m);
      logic [12:0]          prod;
      logic [BIN_WIDTH-1:0] q;
      begin
         prod = 13'(v) * 13'(lv - LVL_WIDTH'(1));
         q    = '0;
         for (int b = 1; b < MAX_LEVELS; b++) begin
            if (LVL_WIDTH'(b) < lv && 13'(b) * 13'(m) <= prod) begin
               q = BIN_WIDTH'(b);
            end
         end
         bin_of = q;
      end
   endfunction

   logic [BIN_WIDTH-1:0] b_r, b_g, b_b;
   logic                 black;
   logic                 count_en;

   assign b_r      = bin_of(req.red, levels, m_eff);
   assign b_g      = bin_of(req.green, levels, m_eff);
   assign b_b      = bin_of(req.blue, levels, m_eff);
   assign black    = (req.red == 8'd0) && (req.green == 8'd0) && (req.blue == 8'd0);
   assign count_en = cmd.accum && !black;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [TOTAL_WIDTH-1:0] TOT_MAX = '1;

   // Each channel bank takes one write a cycle: a clear sweep slot or its counted bin.
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         red_ff[clr_ff]   <= '0;
         green_ff[clr_ff] <= '0;
         blue_ff[clr_ff]  <= '0;
      end else if (count_en) begin
         if (red_ff[b_r] != CNT_MAX) begin
            red_ff[b_r] <= red_ff[b_r] + COUNT_WIDTH'(1);
         end
         if (green_ff[b_g] != CNT_MAX) begin
            green_ff[b_g] <= green_ff[b_g] + COUNT_WIDTH'(1);
         end
         if (blue_ff[b_b] != CNT_MAX) begin
            blue_ff[b_b] <= blue_ff[b_b] + COUNT_WIDTH'(1);
         end
      end
   end

   logic [TOTAL_WIDTH:0] tot_sum;
   assign tot_sum = {1'b0, total_ff} + (TOTAL_WIDTH + 1)'(3);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         clr_ff   <= '0;
      end else begin
         if (cmd.clear_done) begin
            total_ff <= '0;
         end else if (count_en) begin
            total_ff <= tot_sum[TOTAL_WIDTH] ? TOT_MAX : tot_sum[TOTAL_WIDTH-1:0];
         end
         if (cmd.clear_step) begin
            clr_ff <= cmd.clear_done ? '0 : clr_ff + BIN_WIDTH'(1);
         end
      end
   end

   assign stat.clear_last = (clr_ff == BIN_WIDTH'(MAX_LEVELS - 1));

   // Walk position over channel and bin.
   assign top_bin        = (LVL_WIDTH'(bin_ff) == levels - LVL_WIDTH'(1));
   assign stat.walk_last = top_bin && (ch_ff == 2'd2);
   assign flat           = 6'(6'(ch_ff) * 6'(levels) + 6'(bin_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff  <= '0;
         bin_ff <= '0;
      end else if (cmd.emit) begin
         if (stat.walk_last) begin
            ch_ff  <= '0;
            bin_ff <= '0;
         end else if (top_bin) begin
            ch_ff  <= ch_ff + 2'd1;
            bin_ff <= '0;
         end else begin
            bin_ff <= bin_ff + BIN_WIDTH'(1);
         end
      end
   end

   logic [COUNT_WIDTH-1:0] rd_count;
   always_comb begin
      unique case (ch_ff)
         2'd0:    rd_count = red_ff[bin_ff];
         2'd1:    rd_count = green_ff[bin_ff];
         default: rd_count = blue_ff[bin_ff];
      endcase
   end

   // Restoring divide of count*65536 by total, one quotient bit a cycle.
   logic [TOTAL_WIDTH:0] rem_try;
   logic [TOTAL_WIDTH:0] rem_sh;
   assign rem_sh   = {rem_ff[TOTAL_WIDTH-1:0], quo_ff[NUM_WIDTH-1]};
   assign rem_try  = rem_sh - {1'b0, total_ff};
   assign stat.div_done = (step_ff == STEP_WIDTH'(DIV_STEPS));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.div_start) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + STEP_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         cnt_ff <= rd_count;
         quo_ff <= {rd_count, 16'd0};
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (!rem_try[TOTAL_WIDTH]) begin
            rem_ff <= rem_try;
            quo_ff <= {quo_ff[NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[NUM_WIDTH-2:0], 1'b0};
         end
      end
   end

   logic [15:0] frac;
   always_comb begin
      if (total_ff == '0) begin
         frac = 16'd0;
      end else if (quo_ff[NUM_WIDTH-1:16] != '0) begin
         frac = 16'hFFFF;
      end else begin
         frac = quo_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_ff.bin_index    <= flat;
         rsp_ff.bin_count    <= 20'(cnt_ff);
         rsp_ff.bin_fraction <= frac;
         rsp_ff.last_bin     <= stat.walk_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
